/* design/heightmap_bilinear_sample_macros.svh */
// assertion macros for the heightmap bilinear sampler
// used by heightmap_bilinear_sample.sv; expects i_clk and i_rst_n in scope
`ifndef HEIGHTMAP_BILINEAR_SAMPLE_MACROS_SVH
`define HEIGHTMAP_BILINEAR_SAMPLE_MACROS_SVH

// same-cycle implication, checked out of reset
`define HBS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("heightmap sampler check failed");

// next-cycle implication, checked out of reset
`define HBS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("heightmap sampler check failed");

`endif

/* design/hbs_pkg.sv */
// shared types, constants and helpers of the heightmap bilinear sampler
// no dependencies; used by every module of the block but hbs_grid_mem
`default_nettype none

package hbs_pkg;

    localparam int POS_W        = 32;
    localparam int CFG_W        = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int GRID_INDEX_W = 9;
    localparam int LOAD_W       = 20;
    localparam int WATER_W      = 20;
    localparam int HEIGHT_OUT_W = 20;
    localparam int FRAC_W       = 8;
    localparam int OUT_SHIFT    = 16;
    localparam int CLAMP_W      = 34;
    localparam int ROUND_BIAS   = 5;

    localparam logic [HEIGHT_OUT_W-1:0] OUT_MAX = '1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INV_SCALE   = 2'd0,
        CFG_WATER_MODE  = 2'd1,
        CFG_WATER_LEVEL = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Z,
        ST_RANGE,
        ST_RD_BOT,
        ST_LATCH,
        ST_LEFT,
        ST_RIGHT,
        ST_BLEND,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic en;
        logic sel_z;
    } t_coord_ctrl;

    typedef struct packed {
        logic left;
        logic right;
        logic blend;
    } t_interp_ctrl;

    // negative to zero, above the field to its maximum
    function automatic logic [HEIGHT_OUT_W-1:0] clamp_height(input logic signed [CLAMP_W-1:0] v);
        logic [HEIGHT_OUT_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > signed'({{(CLAMP_W-HEIGHT_OUT_W){1'b0}}, OUT_MAX})) begin
            res = OUT_MAX;
        end else begin
            res = v[HEIGHT_OUT_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* design/hbs_grid_mem.sv */
// height grid store: one write port, two read ports, registered read data
// depends on nothing but its parameters
`default_nettype none

module hbs_grid_mem #(
    parameter int DEPTH = 289,
    parameter int AW    = 9,
    parameter int DW    = 20
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [DW-1:0] i_wr_data,
    input  wire logic [AW-1:0] i_rd_addr_a,
    input  wire logic [AW-1:0] i_rd_addr_b,
    output logic      [DW-1:0] o_rd_data_a,
    output logic      [DW-1:0] o_rd_data_b
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule

`default_nettype wire

/* design/hbs_coord.sv */
// world position to grid cell and fraction, one shared 31x32 multiplier
// depends on hbs_pkg
`default_nettype none

module hbs_coord #(
    parameter int GRID_SIZE = 17
) (
    input  wire logic                         i_clk,
    input  wire hbs_pkg::t_coord_ctrl         i_ctrl,
    input  wire logic [hbs_pkg::POS_W-2:0]    i_pos_x,
    input  wire logic [hbs_pkg::POS_W-2:0]    i_pos_z,
    input  wire logic [hbs_pkg::CFG_W-1:0]    i_inv_scale,
    output logic      [$clog2(GRID_SIZE)-1:0] o_cell,
    output logic      [hbs_pkg::FRAC_W-1:0]   o_frac,
    output logic                              o_cell_ok
);

    localparam int CW       = $clog2(GRID_SIZE);
    localparam int PROD_W   = hbs_pkg::POS_W - 1 + hbs_pkg::CFG_W;
    localparam int CELL_LSB = hbs_pkg::OUT_SHIFT + hbs_pkg::FRAC_W;
    localparam int CELL_FW  = PROD_W - CELL_LSB;
    localparam logic [CELL_FW-1:0] CELL_LIMIT = CELL_FW'(GRID_SIZE - 1);

    logic [hbs_pkg::POS_W-2:0] w_op;
    logic [PROD_W-1:0]         r_prod;

    assign w_op = i_ctrl.sel_z ? i_pos_z : i_pos_x;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_prod <= PROD_W'(w_op) * PROD_W'(i_inv_scale);
        end
    end

    // grid coordinate is product >> 16 with 8 fraction bits
    assign o_frac    = r_prod[hbs_pkg::OUT_SHIFT +: hbs_pkg::FRAC_W];
    assign o_cell    = r_prod[CELL_LSB +: CW];
    assign o_cell_ok = r_prod[PROD_W-1:CELL_LSB] < CELL_LIMIT;

endmodule

`default_nettype wire

/* design/hbs_interp.sv */
// bilinear blend of four corner heights through one shared multiplier
// depends on hbs_pkg
`default_nettype none

module hbs_interp #(
    parameter int HEIGHT_BITS = 20
) (
    input  wire logic                              i_clk,
    input  wire hbs_pkg::t_interp_ctrl             i_ctrl,
    input  wire logic signed [HEIGHT_BITS-1:0]     i_h00,
    input  wire logic signed [HEIGHT_BITS-1:0]     i_h01,
    input  wire logic signed [HEIGHT_BITS-1:0]     i_h10,
    input  wire logic signed [HEIGHT_BITS-1:0]     i_h11,
    input  wire logic [hbs_pkg::FRAC_W-1:0]        i_fx,
    input  wire logic [hbs_pkg::FRAC_W-1:0]        i_fz,
    output logic      [hbs_pkg::HEIGHT_OUT_W-1:0]  o_height
);

    localparam int LW = HEIGHT_BITS + hbs_pkg::FRAC_W;   // one axis blended, scaled by 256
    localparam int DW = LW + 1;
    localparam int PW = DW + hbs_pkg::FRAC_W + 1;
    localparam int VW = HEIGHT_BITS + 2 * hbs_pkg::FRAC_W + 1;
    localparam logic signed [PW-1:0] BIAS_V = PW'(hbs_pkg::ROUND_BIAS) <<< hbs_pkg::OUT_SHIFT;

    logic signed [DW-1:0]               w_diff;
    logic signed [hbs_pkg::FRAC_W:0]    w_frac;
    logic signed [PW-1:0]               w_base;
    logic signed [PW-1:0]               w_prod;
    logic signed [PW-1:0]               w_sum;
    logic                               w_level;
    logic signed [LW-1:0]               r_left;
    logic signed [LW-1:0]               r_right;
    logic signed [VW-1:0]               r_v;
    logic                               r_level;

    // a*(256-f) + b*f rewritten as a*256 + (b-a)*f
    always_comb begin
        if (i_ctrl.left) begin
            w_diff = DW'(i_h10) - DW'(i_h00);
            w_frac = signed'({1'b0, i_fz});
            w_base = PW'(i_h00) <<< hbs_pkg::FRAC_W;
        end else if (i_ctrl.right) begin
            w_diff = DW'(i_h11) - DW'(i_h01);
            w_frac = signed'({1'b0, i_fz});
            w_base = PW'(i_h01) <<< hbs_pkg::FRAC_W;
        end else begin
            w_diff = DW'(r_right) - DW'(r_left);
            w_frac = signed'({1'b0, i_fx});
            w_base = (PW'(r_left) <<< hbs_pkg::FRAC_W) + BIAS_V;
        end
    end

    assign w_prod  = w_diff * w_frac;
    assign w_sum   = w_base + w_prod;
    assign w_level = (i_h00 == i_h10) && (i_h10 == i_h01) && (i_h01 == i_h11);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.left) begin
            r_left  <= w_sum[LW-1:0];
            r_level <= w_level;
        end
        if (i_ctrl.right) begin
            r_right <= w_sum[LW-1:0];
        end
        if (i_ctrl.blend) begin
            r_v <= w_sum[VW-1:0];
        end
    end

    // level cell gives the corner itself, no bias
    assign o_height = r_level
        ? hbs_pkg::clamp_height(hbs_pkg::CLAMP_W'(i_h00))
        : hbs_pkg::clamp_height(hbs_pkg::CLAMP_W'(r_v >>> hbs_pkg::OUT_SHIFT));

endmodule

`default_nettype wire

/* design/heightmap_bilinear_sample.sv */
// top level of the heightmap bilinear sampler: control, configuration, result register
// depends on hbs_pkg, hbs_grid_mem, hbs_coord, hbs_interp and the assertion macro header
//
// The block keeps a GRID_SIZE x GRID_SIZE grid of signed heights in one synchronous
// memory with two read ports. Raise i_start with an item while o_busy is low; the item
// is taken at that clock edge. A load (i_op low) writes one grid entry in the same cycle,
// gives no result and leaves the block free for the next item straight away; indexes past
// the grid are dropped. A query (i_op high) gives exactly one result beat, shown on
// o_height and o_in_grid for a single cycle with o_valid high. There is no back-pressure:
// the result must be taken in that cycle. In water mode, and for a negative position, the
// result appears in the cycle after the query is taken and o_busy stays low. Otherwise the
// position multiplier is used twice (X then Z); a query that lands off the grid cells
// gives its zero result from the range check. A query inside the grid goes through two
// passes on the position multiplier, one range check, two row reads through the memory's
// two read ports, three passes through the interpolation multiplier and one step to
// register the result. Entries never loaded read back as whatever the memory holds.
// Register writes are taken at once and should be made only while no query is in flight.
`default_nettype none

`include "heightmap_bilinear_sample_macros.svh"

module heightmap_bilinear_sample #(
    parameter int GRID_SIZE   = 17,
    parameter int HEIGHT_BITS = 20
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // item beat
    input  wire logic                                   i_start,
    output logic                                        o_busy,
    input  wire logic                                   i_op,
    input  wire logic        [hbs_pkg::GRID_INDEX_W-1:0] i_grid_index,
    input  wire logic signed [hbs_pkg::LOAD_W-1:0]       i_load_height,
    input  wire logic signed [hbs_pkg::POS_W-1:0]        i_pos_x,
    input  wire logic signed [hbs_pkg::POS_W-1:0]        i_pos_z,
    // result beat
    output logic                                        o_valid,
    output logic             [hbs_pkg::HEIGHT_OUT_W-1:0] o_height,
    output logic                                        o_in_grid,
    // register writes
    input  wire logic                                   i_cfg_we,
    input  wire logic        [hbs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic        [hbs_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int CELLS = GRID_SIZE * GRID_SIZE;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(GRID_SIZE);
    localparam logic [AW-1:0] ROW_STEP = AW'(GRID_SIZE);
    localparam logic [hbs_pkg::CFG_W-1:0] INV_SCALE_RST = 32'd65536;

    // configuration
    logic [hbs_pkg::CFG_W-1:0]          r_inv_scale;
    logic                               r_water_mode;
    logic signed [hbs_pkg::WATER_W-1:0] r_water_level;

    // control
    hbs_pkg::t_state       r_state;
    hbs_pkg::t_state       n_state;
    hbs_pkg::t_coord_ctrl  w_coord_ctrl;
    hbs_pkg::t_interp_ctrl w_interp_ctrl;
    logic                  w_accept;
    logic                  w_mem_we;
    logic                  w_lat_pos;
    logic                  w_lat_x;
    logic                  w_lat_z;
    logic                  w_lat_top;
    logic                  w_lat_bot;

    // result register
    logic                              r_valid;
    logic                              n_valid;
    logic [hbs_pkg::HEIGHT_OUT_W-1:0]  r_height;
    logic [hbs_pkg::HEIGHT_OUT_W-1:0]  n_height;
    logic                              r_in_grid;
    logic                              n_in_grid;

    // datapath
    logic [hbs_pkg::POS_W-2:0]         r_pos_x;
    logic [hbs_pkg::POS_W-2:0]         r_pos_z;
    logic [CW-1:0]                     w_cell;
    logic [hbs_pkg::FRAC_W-1:0]        w_frac;
    logic                              w_cell_ok;
    logic [CW-1:0]                     r_cx;
    logic [hbs_pkg::FRAC_W-1:0]        r_fx;
    logic [hbs_pkg::FRAC_W-1:0]        r_fz;
    logic                              r_x_ok;
    logic [AW-1:0]                     w_base;
    logic [AW-1:0]                     r_base;
    logic [AW-1:0]                     w_rd_addr_a;
    logic [AW-1:0]                     w_rd_addr_b;
    logic [HEIGHT_BITS-1:0]            w_rd_data_a;
    logic [HEIGHT_BITS-1:0]            w_rd_data_b;
    logic signed [HEIGHT_BITS-1:0]     r_h00;
    logic signed [HEIGHT_BITS-1:0]     r_h01;
    logic signed [HEIGHT_BITS-1:0]     r_h10;
    logic signed [HEIGHT_BITS-1:0]     r_h11;
    logic [hbs_pkg::HEIGHT_OUT_W-1:0]  w_interp_height;

    assign o_busy    = (r_state != hbs_pkg::ST_IDLE);
    assign w_accept  = i_start && !o_busy;
    // loads go straight into the grid; writes past the last entry are dropped
    assign w_mem_we  = w_accept && (i_op == hbs_pkg::OP_LOAD) && (int'(i_grid_index) < CELLS);
    assign o_valid   = r_valid;
    assign o_height  = r_height;
    assign o_in_grid = r_in_grid;

    // register writes, no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_scale   <= INV_SCALE_RST;
            r_water_mode  <= 1'b0;
            r_water_level <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hbs_pkg::CFG_INV_SCALE:   r_inv_scale   <= i_cfg_data;
                hbs_pkg::CFG_WATER_MODE:  r_water_mode  <= i_cfg_data[0];
                hbs_pkg::CFG_WATER_LEVEL: r_water_level <= i_cfg_data[hbs_pkg::WATER_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hbs_pkg::ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_valid       = 1'b0;
        n_height      = r_height;
        n_in_grid     = r_in_grid;
        w_coord_ctrl  = '0;
        w_interp_ctrl = '0;
        w_lat_pos     = 1'b0;
        w_lat_x       = 1'b0;
        w_lat_z       = 1'b0;
        w_lat_top     = 1'b0;
        w_lat_bot     = 1'b0;
        unique case (r_state)
            hbs_pkg::ST_IDLE: begin
                if (w_accept && (i_op == hbs_pkg::OP_QUERY)) begin
                    if (r_water_mode) begin
                        // flat water patch, in_grid held low
                        n_valid   = 1'b1;
                        n_height  = hbs_pkg::clamp_height(hbs_pkg::CLAMP_W'(r_water_level));
                        n_in_grid = 1'b0;
                    end else if (i_pos_x[hbs_pkg::POS_W-1] || i_pos_z[hbs_pkg::POS_W-1]) begin
                        // negative position lies off the grid
                        n_valid   = 1'b1;
                        n_height  = '0;
                        n_in_grid = 1'b0;
                    end else begin
                        w_lat_pos = 1'b1;
                        n_state   = hbs_pkg::ST_MUL_X;
                    end
                end
            end
            hbs_pkg::ST_MUL_X: begin
                w_coord_ctrl.en    = 1'b1;
                w_coord_ctrl.sel_z = 1'b0;
                n_state            = hbs_pkg::ST_MUL_Z;
            end
            hbs_pkg::ST_MUL_Z: begin
                // x product is out of the multiplier now
                w_coord_ctrl.en    = 1'b1;
                w_coord_ctrl.sel_z = 1'b1;
                w_lat_x            = 1'b1;
                n_state            = hbs_pkg::ST_RANGE;
            end
            hbs_pkg::ST_RANGE: begin
                if (!(r_x_ok && w_cell_ok)) begin
                    // last row or column, or beyond
                    n_valid   = 1'b1;
                    n_height  = '0;
                    n_in_grid = 1'b0;
                    n_state   = hbs_pkg::ST_IDLE;
                end else begin
                    // top row pair is being read
                    w_lat_z = 1'b1;
                    n_state = hbs_pkg::ST_RD_BOT;
                end
            end
            hbs_pkg::ST_RD_BOT: begin
                w_lat_top = 1'b1;
                n_state   = hbs_pkg::ST_LATCH;
            end
            hbs_pkg::ST_LATCH: begin
                w_lat_bot = 1'b1;
                n_state   = hbs_pkg::ST_LEFT;
            end
            hbs_pkg::ST_LEFT: begin
                w_interp_ctrl.left = 1'b1;
                n_state            = hbs_pkg::ST_RIGHT;
            end
            hbs_pkg::ST_RIGHT: begin
                w_interp_ctrl.right = 1'b1;
                n_state             = hbs_pkg::ST_BLEND;
            end
            hbs_pkg::ST_BLEND: begin
                w_interp_ctrl.blend = 1'b1;
                n_state             = hbs_pkg::ST_OUT;
            end
            hbs_pkg::ST_OUT: begin
                n_valid   = 1'b1;
                n_height  = w_interp_height;
                n_in_grid = 1'b1;
                n_state   = hbs_pkg::ST_IDLE;
            end
            default: begin
                n_state = hbs_pkg::ST_IDLE;
            end
        endcase
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_height  <= n_height;
        r_in_grid <= n_in_grid;
        if (w_lat_pos) begin
            r_pos_x <= i_pos_x[hbs_pkg::POS_W-2:0];
            r_pos_z <= i_pos_z[hbs_pkg::POS_W-2:0];
        end
        if (w_lat_x) begin
            r_cx   <= w_cell;
            r_fx   <= w_frac;
            r_x_ok <= w_cell_ok;
        end
        if (w_lat_z) begin
            r_fz   <= w_frac;
            r_base <= w_base;
        end
        if (w_lat_top) begin
            r_h00 <= w_rd_data_a;
            r_h01 <= w_rd_data_b;
        end
        if (w_lat_bot) begin
            r_h10 <= w_rd_data_a;
            r_h11 <= w_rd_data_b;
        end
    end

    // row z0 during the range check, row z0+1 after it; column pair on the two ports
    assign w_base      = AW'(w_cell) * ROW_STEP + AW'(r_cx);
    assign w_rd_addr_a = (r_state == hbs_pkg::ST_RANGE) ? w_base : (r_base + ROW_STEP);
    assign w_rd_addr_b = w_rd_addr_a + AW'(1);

    hbs_grid_mem #(
        .DEPTH (CELLS),
        .AW    (AW),
        .DW    (HEIGHT_BITS)
    ) u_grid_mem (
        .i_clk       (i_clk),
        .i_we        (w_mem_we),
        .i_wr_addr   (AW'(i_grid_index)),
        .i_wr_data   (HEIGHT_BITS'(i_load_height)),
        .i_rd_addr_a (w_rd_addr_a),
        .i_rd_addr_b (w_rd_addr_b),
        .o_rd_data_a (w_rd_data_a),
        .o_rd_data_b (w_rd_data_b)
    );

    hbs_coord #(
        .GRID_SIZE (GRID_SIZE)
    ) u_coord (
        .i_clk       (i_clk),
        .i_ctrl      (w_coord_ctrl),
        .i_pos_x     (r_pos_x),
        .i_pos_z     (r_pos_z),
        .i_inv_scale (r_inv_scale),
        .o_cell      (w_cell),
        .o_frac      (w_frac),
        .o_cell_ok   (w_cell_ok)
    );

    hbs_interp #(
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_interp (
        .i_clk    (i_clk),
        .i_ctrl   (w_interp_ctrl),
        .i_h00    (r_h00),
        .i_h01    (r_h01),
        .i_h10    (r_h10),
        .i_h11    (r_h11),
        .i_fx     (r_fx),
        .i_fz     (r_fz),
        .o_height (w_interp_height)
    );

    // range check either answers at once or moves on to the second row read
    `HBS_ASSERT_NXT(a_range_outcome, r_state == hbs_pkg::ST_RANGE, o_valid || r_state == hbs_pkg::ST_RD_BOT)
    // a finished blend always leaves one result beat and frees the block
    `HBS_ASSERT_NXT(a_out_done, r_state == hbs_pkg::ST_OUT, o_valid && o_in_grid && !o_busy)
    // the grid is never written while a query is using the memory
    `HBS_ASSERT_IMP(a_load_idle, w_mem_we, r_state == hbs_pkg::ST_IDLE)
    // a result beat only ever follows idle, the range check or the output step
    `HBS_ASSERT_IMP(a_valid_src, o_valid, $past(r_state) == hbs_pkg::ST_IDLE || $past(r_state) == hbs_pkg::ST_RANGE || $past(r_state) == hbs_pkg::ST_OUT)

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// self-checking testbench for heightmap_bilinear_sample: command beats in, height strobes out
// needs hbs_pkg for widths, opcodes and register indexes; predicts each height on its own
module tb;
    import hbs_pkg::*;

    localparam int GRID_N     = 17;
    localparam int CELL_COUNT = GRID_N * GRID_N;
    localparam int LAST_CELL  = GRID_N - 1;
    localparam int BIAS       = 5;
    localparam int SETTLE_CYC = 12;
    localparam int RUN_LIMIT  = 2000000;

    typedef struct {
        logic                     op;
        logic [GRID_INDEX_W-1:0]  grid_index;
        logic signed [LOAD_W-1:0] load_height;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_z;
    } t_hm_item;

    typedef struct {
        logic [HEIGHT_OUT_W-1:0] height;
        logic                    in_grid;
    } t_sample;

    // dut ports, the driven inputs known from time zero
    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_start = 1'b0;
    logic                      o_busy;
    logic                      i_op = OP_LOAD;
    logic [GRID_INDEX_W-1:0]   i_grid_index = '0;
    logic signed [LOAD_W-1:0]  i_load_height = '0;
    logic signed [POS_W-1:0]   i_pos_x = '0;
    logic signed [POS_W-1:0]   i_pos_z = '0;
    logic                      o_valid;
    logic [HEIGHT_OUT_W-1:0]   o_height;
    logic                      o_in_grid;
    logic                      i_cfg_we = 1'b0;
    t_cfg_idx                  i_cfg_index = CFG_INV_SCALE;
    logic [CFG_W-1:0]          i_cfg_data = '0;

    // predictor state: grid copy and register copies
    logic signed [LOAD_W-1:0]  grid_model [0:CELL_COUNT-1];
    logic [CFG_W-1:0]          cfg_inv_scale = 32'h0001_0000;
    logic                      cfg_water_mode = 1'b0;
    logic signed [WATER_W-1:0] cfg_water_level = '0;

    t_hm_item item_q [$];         // commands waiting to be driven
    t_sample  height_due_q [$];   // heights owed by accepted queries, oldest first
    t_hm_item next_item;

    int sender_idle_pct = 16;
    int err_count = 0;
    int loads_seen = 0;
    int queries_seen = 0;
    int in_grid_seen = 0;
    int reg_writes = 0;

    heightmap_bilinear_sample dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_op          (i_op),
        .i_grid_index  (i_grid_index),
        .i_load_height (i_load_height),
        .i_pos_x       (i_pos_x),
        .i_pos_z       (i_pos_z),
        .o_valid       (o_valid),
        .o_height      (o_height),
        .o_in_grid     (o_in_grid),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // reset held low from the start, released once
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // hard stop in case a beat never comes
    initial begin
        #(RUN_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // negative to zero, past the 20-bit field to its top
    function automatic logic [HEIGHT_OUT_W-1:0] clamp_to_field(input longint v);
        if (v < 0) begin
            return '0;
        end else if (v > longint'(20'hFFFFF)) begin
            return '1;
        end
        return v[HEIGHT_OUT_W-1:0];
    endfunction

    // height and in-grid flag owed for a query under the current grid and registers
    function automatic t_sample sample_height(input logic signed [POS_W-1:0] px,
                                              input logic signed [POS_W-1:0] pz);
        t_sample res;
        logic [63:0] gx, gz, x0, z0;
        longint fx, fz, h00, h10, h01, h11, lft, rgt, acc;
        int base;
        res.height = '0;
        res.in_grid = 1'b0;
        if (cfg_water_mode) begin
            res.height = clamp_to_field(longint'(cfg_water_level));
            return res;
        end
        // negative world positions never land on the grid
        if (px < 0 || pz < 0) begin
            return res;
        end
        gx = ({32'd0, px} * {32'd0, cfg_inv_scale}) >> 16;
        gz = ({32'd0, pz} * {32'd0, cfg_inv_scale}) >> 16;
        x0 = gx >> FRAC_W;
        z0 = gz >> FRAC_W;
        fx = gx & 64'hFF;
        fz = gz & 64'hFF;
        // the last row and column hold no cell of their own
        if (x0 >= LAST_CELL || z0 >= LAST_CELL) begin
            return res;
        end
        res.in_grid = 1'b1;
        base = int'(z0) * GRID_N + int'(x0);
        h00 = grid_model[base];
        h10 = grid_model[base + GRID_N];
        h01 = grid_model[base + 1];
        h11 = grid_model[base + GRID_N + 1];
        // a level cell gives its corner height with no bias
        if (h00 == h10 && h10 == h01 && h01 == h11) begin
            res.height = clamp_to_field(h00);
            return res;
        end
        lft = h00 * (256 - fz) + h10 * fz;
        rgt = h01 * (256 - fz) + h11 * fz;
        acc = lft * (256 - fx) + rgt * fx + longint'(BIAS) * 65536;
        res.height = (acc < 0) ? '0 : clamp_to_field(acc >>> 16);
        return res;
    endfunction

    // driver: keeps start up until the beat is taken, idles at random between beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (!i_start || !o_busy) begin
            if (item_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                next_item = item_q.pop_front();
                i_start       <= 1'b1;
                i_op          <= next_item.op;
                i_grid_index  <= next_item.grid_index;
                i_load_height <= next_item.load_height;
                i_pos_x       <= next_item.pos_x;
                i_pos_z       <= next_item.pos_z;
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // monitor: checks each strobe against the oldest owed height, then books new beats
    always @(posedge i_clk) begin : monitor
        t_sample want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (height_due_q.size() == 0) begin
                    $error("result beat with no query waiting: height %0d in_grid %0b",
                           o_height, o_in_grid);
                    err_count++;
                end else begin
                    want = height_due_q.pop_front();
                    if (o_height !== want.height) begin
                        $error("height: expected %0d, got %0d", want.height, o_height);
                        err_count++;
                    end
                    if (o_in_grid !== want.in_grid) begin
                        $error("in_grid: expected %0b, got %0b", want.in_grid, o_in_grid);
                        err_count++;
                    end
                    if (want.in_grid) begin
                        in_grid_seen++;
                    end
                end
            end
            if (i_start && !o_busy) begin
                if (i_op == OP_LOAD) begin
                    // writes past the grid are dropped
                    if (i_grid_index < CELL_COUNT) begin
                        grid_model[i_grid_index] = i_load_height;
                    end
                    loads_seen++;
                end else begin
                    height_due_q.push_back(sample_height(i_pos_x, i_pos_z));
                    queries_seen++;
                end
            end
        end
    end

    task automatic push_load(input int idx, input logic signed [LOAD_W-1:0] h);
        t_hm_item it;
        it.op = OP_LOAD;
        it.grid_index = idx[GRID_INDEX_W-1:0];
        it.load_height = h;
        it.pos_x = $urandom;
        it.pos_z = $urandom;
        item_q.push_back(it);
    endtask

    task automatic push_query(input logic signed [POS_W-1:0] px,
                              input logic signed [POS_W-1:0] pz);
        t_hm_item it;
        it.op = OP_QUERY;
        it.grid_index = GRID_INDEX_W'($urandom);
        it.load_height = LOAD_W'($urandom);
        it.pos_x = px;
        it.pos_z = pz;
        item_q.push_back(it);
    endtask

    // only while nothing is in flight
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_INV_SCALE:   cfg_inv_scale = data;
            CFG_WATER_MODE:  cfg_water_mode = data[0];
            CFG_WATER_LEVEL: cfg_water_level = data[WATER_W-1:0];
            default: ;
        endcase
        reg_writes++;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait for every beat to be taken and every height to come back, then drain
    task automatic settle();
        do begin
            @(negedge i_clk);
        end while (item_q.size() > 0 || i_start || height_due_q.size() > 0);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    // mix of extremes, small values and anything at all
    function automatic logic signed [LOAD_W-1:0] rand_height();
        case ($urandom_range(3))
            0: return $urandom_range(1) ? 20'sh7FFFF : 20'sh80000;
            1: return LOAD_W'($signed($urandom_range(2000)) - 1000);
            default: return LOAD_W'($urandom);
        endcase
    endfunction

    // world position that maps to grid coordinate g (8 fraction bits) under the scale
    function automatic logic signed [POS_W-1:0] aim_pos(input logic [15:0] g);
        logic [63:0] p;
        if (cfg_inv_scale == 0) begin
            return $urandom & 32'h7FFF_FFFF;
        end
        p = ({48'd0, g} << 16) / {32'd0, cfg_inv_scale} + $urandom_range(1);
        if (p > 64'h7FFF_FFFF) begin
            p = 64'h7FFF_FFFF;
        end
        return p[POS_W-1:0];
    endfunction

    task automatic push_random_query();
        int pick;
        logic signed [POS_W-1:0] px, pz;
        pick = $urandom_range(99);
        if (pick < 65) begin
            px = aim_pos(16'($urandom_range(4095)));
            pz = aim_pos(16'($urandom_range(4095)));
        end else if (pick < 75) begin
            // just past the last cell on one axis
            px = aim_pos(16'($urandom_range(4095)));
            pz = aim_pos(16'($urandom_range(4400, 4096)));
            if ($urandom_range(1)) begin
                {px, pz} = {pz, px};
            end
        end else if (pick < 85) begin
            px = aim_pos(16'($urandom_range(4095)));
            pz = $urandom | 32'h8000_0000;
            if ($urandom_range(1)) begin
                {px, pz} = {pz, px};
            end
        end else begin
            px = $urandom;
            pz = $urandom;
        end
        push_query(px, pz);
    endtask

    task automatic run_random(input int n_items, input int idle_pct);
        int made, pick, row, col, idx;
        logic signed [LOAD_W-1:0] v;
        sender_idle_pct = idle_pct;
        made = 0;
        while (made < n_items) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                // flatten one cell then sample inside it
                row = $urandom_range(LAST_CELL - 1);
                col = $urandom_range(LAST_CELL - 1);
                idx = row * GRID_N + col;
                v = rand_height();
                push_load(idx, v);
                push_load(idx + 1, v);
                push_load(idx + GRID_N, v);
                push_load(idx + GRID_N + 1, v);
                push_query(aim_pos(16'(col * 256 + $urandom_range(255))),
                           aim_pos(16'(row * 256 + $urandom_range(255))));
                made += 5;
            end else if (pick < 35) begin
                idx = ($urandom_range(9) == 0) ? $urandom_range(511, CELL_COUNT)
                                               : $urandom_range(CELL_COUNT - 1);
                push_load(idx, rand_height());
                made++;
            end else begin
                push_random_query();
                made++;
            end
        end
        settle();
    endtask

    initial begin : stimulus
        while (!i_rst_n) @(posedge i_clk);

        // every entry written first, so no query reads an unwritten one
        for (int k = 0; k < CELL_COUNT; k++) begin
            push_load(k, rand_height());
        end

        // directed: level cell at the top value
        push_load(0, 20'sh7FFFF);
        push_load(1, 20'sh7FFFF);
        push_load(GRID_N, 20'sh7FFFF);
        push_load(GRID_N + 1, 20'sh7FFFF);
        // level cell at the bottom value, clamps to zero
        push_load(2 * GRID_N + 2, 20'sh80000);
        push_load(2 * GRID_N + 3, 20'sh80000);
        push_load(3 * GRID_N + 2, 20'sh80000);
        push_load(3 * GRID_N + 3, 20'sh80000);
        // crossed extremes at cell (6,6)
        push_load(6 * GRID_N + 6, 20'sh7FFFF);
        push_load(6 * GRID_N + 7, 20'sh80000);
        push_load(7 * GRID_N + 6, 20'sh80000);
        push_load(7 * GRID_N + 7, 20'sh7FFFF);
        // slightly uneven negative cell at (8,8): blend stays below zero
        push_load(8 * GRID_N + 8, -20'sd100);
        push_load(8 * GRID_N + 9, -20'sd100);
        push_load(9 * GRID_N + 8, -20'sd100);
        push_load(9 * GRID_N + 9, -20'sd99);
        // out-of-range writes, dropped
        push_load(CELL_COUNT, 20'sh7FFFF);
        push_load(511, -20'sd1);
        // unit scale, so grid coordinate equals position
        push_query(32'sh0, 32'sh0);
        push_query(32'sh0FF, 32'sh0FF);
        push_query(32'sh280, 32'sh280);
        push_query(32'sh680, 32'sh640);
        push_query(32'sh8FF, 32'sh8FF);
        push_query(32'shFFF, 32'shFFF);       // far corner of the last cell
        push_query(32'sh1000, 32'sh800);      // last column
        push_query(32'sh800, 32'sh1000);      // last row
        push_query(-32'sd1, 32'sh100);
        push_query(32'sh100, 32'sh8000_0000);
        push_query(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        settle();

        // sender idles 16 in 100
        write_reg(CFG_INV_SCALE, 32'h0001_8000);
        run_random(80, 16);
        write_reg(CFG_INV_SCALE, 32'h0000_4000);
        run_random(60, 16);

        // sender idles 80 in 100, with the scale extremes and water mode
        write_reg(CFG_INV_SCALE, 32'hFFFF_FFFF);
        run_random(40, 80);
        write_reg(CFG_INV_SCALE, 32'h0000_0000);
        run_random(30, 80);
        write_reg(CFG_WATER_LEVEL, 32'h0007_FFFF);
        write_reg(CFG_WATER_MODE, 32'd1);
        run_random(20, 80);
        write_reg(CFG_WATER_LEVEL, 32'hFFF8_0000);
        run_random(20, 80);
        write_reg(CFG_WATER_LEVEL, $urandom);
        run_random(20, 80);
        write_reg(CFG_WATER_MODE, 32'd0);
        write_reg(CFG_WATER_LEVEL, 32'd0);

        // back to back
        write_reg(CFG_INV_SCALE, 32'h0001_0000);
        run_random(80, 0);
        write_reg(CFG_INV_SCALE, $urandom_range(32'h0006_0000, 32'h0000_2000));
        run_random(80, 0);

        $display("covered %0d grid loads and %0d height queries (%0d landed on grid cells)",
                 loads_seen, queries_seen, in_grid_seen);
        $display("across %0d register writes: scale extremes, water mode, three idle mixes",
                 reg_writes);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
